FILE: design/sound_effect_synth_assert.svh
// Assertion macros shared by the sound effect synth checker.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef SOUND_EFFECT_SYNTH_ASSERT_SVH
`define SOUND_EFFECT_SYNTH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFX_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFX_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/sfx_pkg.sv
// Shared types, constants and the effect descriptor table for the sound effect synth.
// No dependencies; sfx_div, sfx_queue and sound_effect_synth import this package.
package sfx_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PHASE_BITS_DEF  = 24;

    localparam int NUM_EFFECTS = 9;
    localparam int EFFECT_W    = 4;
    localparam int SAMPLE_W    = 15;
    localparam int LEN_W       = 11;   // longest effect is 1280 samples
    localparam int IDX_W       = 11;
    localparam int DEN_W       = 25;   // 16000 * 1280 < 2^25
    localparam int FREQ_W      = 21;   // f * len < 2^21
    localparam int DF_W        = 11;   // signed sweep, -1000..500
    localparam int AMP_W       = 13;
    localparam int ENV_W       = 13;
    localparam int NOISE_W     = 16;
    localparam int MOD_W       = 13;   // noise modulus up to 5000
    localparam int DIV_BITS    = 26;   // envelope dividend, 7000 * 6000 < 2^26
    localparam int STEP_W      = 6;
    localparam int SAMPLE_RATE = 16000;

    localparam logic [NOISE_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [NOISE_W-1:0] SEED_MIN  = 16'h0001;

    localparam logic [EFFECT_W-1:0] EFX_JUMP      = 4'd0;
    localparam logic [EFFECT_W-1:0] EFX_AIR_BOOST = 4'd1;
    localparam logic [EFFECT_W-1:0] EFX_BLINK     = 4'd2;
    localparam logic [EFFECT_W-1:0] EFX_SLIDE     = 4'd3;
    localparam logic [EFFECT_W-1:0] EFX_DRONE     = 4'd4;
    localparam logic [EFFECT_W-1:0] EFX_VENT      = 4'd5;
    localparam logic [EFFECT_W-1:0] EFX_GEM       = 4'd6;
    localparam logic [EFFECT_W-1:0] EFX_HURT      = 4'd7;
    localparam logic [EFFECT_W-1:0] EFX_GAME_OVER = 4'd8;

    typedef enum logic [2:0] {
        KIND_SQ,
        KIND_BLINK,
        KIND_NOISE,
        KIND_GEM,
        KIND_SAW
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PUSH,
        ST_CHECK,
        ST_POP,
        ST_INC,
        ST_INC_W,
        ST_INC2,
        ST_INC2_W,
        ST_ENV,
        ST_ENV_W,
        ST_NOISE,
        ST_NOISE_W,
        ST_SLIDE,
        ST_SLIDE_W,
        ST_SAW,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0]         len;
        logic [DEN_W-1:0]         den;    // sample rate * len
        logic [FREQ_W-1:0]        f0n;    // start frequency * len
        logic signed [DF_W-1:0]   df;
        logic [FREQ_W-1:0]        f2n;    // second tone * len
        logic [AMP_W-1:0]         amp;
        logic [MOD_W-1:0]         noise;
        kind_t                    kind;
    } fx_desc_t;

    typedef struct packed {
        logic              start;
        logic [DEN_W-1:0]  hi;
        logic [DEN_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    function automatic fx_desc_t fx_make(input int len, input int f0, input int df,
                                         input int f2, input int amp, input int noise,
                                         input kind_t kind);
        fx_desc_t d;
        d.len   = LEN_W'(len);
        d.den   = DEN_W'(SAMPLE_RATE * len);
        d.f0n   = FREQ_W'(f0 * len);
        d.df    = DF_W'(df);
        d.f2n   = FREQ_W'(f2 * len);
        d.amp   = AMP_W'(amp);
        d.noise = MOD_W'(noise);
        d.kind  = kind;
        return d;
    endfunction

    function automatic fx_desc_t fx_lookup(input logic [EFFECT_W-1:0] e);
        fx_desc_t d;
        case (e)
            EFX_JUMP:      d = fx_make(400,  350,   500,    0, 6000,    0, KIND_SQ);
            EFX_AIR_BOOST: d = fx_make(400,  600,   400,    0, 6500, 1600, KIND_SQ);
            EFX_BLINK:     d = fx_make(600, 1300, -1000,    0, 7000,    0, KIND_BLINK);
            EFX_SLIDE:     d = fx_make(480,    0,     0,    0,    0, 5000, KIND_NOISE);
            EFX_DRONE:     d = fx_make(560,  300,  -200,    0, 8000, 3600, KIND_SQ);
            EFX_VENT:      d = fx_make(640,  180,   450,    0, 6500, 2400, KIND_SQ);
            EFX_GEM:       d = fx_make(480,  880,     0, 1320, 4000,    0, KIND_GEM);
            EFX_HURT:      d = fx_make(560,  160,     0,    0, 7000,    0, KIND_SAW);
            EFX_GAME_OVER: d = fx_make(1280, 600,  -520,    0, 7000,    0, KIND_SQ);
            default:       d = fx_make(1,      0,     0,    0,    0,    0, KIND_SQ);
        endcase
        return d;
    endfunction

endpackage

FILE: design/sfx_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on sfx_pkg for the request struct and widths.
module sfx_div import sfx_pkg::*; #(
    parameter int LW = DIV_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    input  logic [LW-1:0]    req_lo,
    output logic             done,
    output logic [LW-1:0]    quo,
    output logic [DEN_W-1:0] rem
);

    logic              busy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [LW-1:0]     quo_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[LW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.steps;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end else begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.hi;
            quo_reg <= req_lo;
            den_reg <= req.den;
        end else if (busy_reg && cnt_reg != '0) begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[LW-2:0], fits};
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

FILE: design/sfx_queue.sv
// Trigger queue: circular buffer of effect codes in a single-port-write memory.
// Depends on sfx_pkg for the effect code width.
module sfx_queue import sfx_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic [EFFECT_W-1:0] push_data,
    input  logic                pop,
    output logic [EFFECT_W-1:0] pop_data,
    output logic                full,
    output logic                empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [EFFECT_W-1:0] mem [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       count_reg;
    logic [EFFECT_W-1:0] pop_data_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            pop_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign pop_data = pop_data_reg;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

endmodule

FILE: design/sound_effect_synth.sv
// Sequence: an idle tick goes from accept through ST_PUSH, ST_CHECK and ST_OUT; a playing tick
//   also waits on up to three divider runs, the two-tone effect taking the longest.
// Throughput: one tick at a time; the shared divider, one quotient bit per cycle, sets the
//   pace. The result waits in an output register while the next tick is accepted.
// Reset (aresetn low, synchronous): empty queue, nothing playing, LFSR loaded with 1.
// Depends on sfx_pkg, sfx_queue and sfx_div.
module sound_effect_synth import sfx_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] effect, [7:4] zero
    input  logic        s_tuser,   // [0] trigger

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [14:0] sample (signed), [15] zero
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [0] active, [1] dropped

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // noise_seed
);

    localparam int PB     = PHASE_BITS;
    localparam int LW     = (PB > DIV_BITS) ? PB : DIV_BITS;
    localparam int NUM_W  = FREQ_W + 3;
    localparam int DFI_W  = DF_W + IDX_W + 1;
    localparam int TEN_W  = LEN_W + 4;
    localparam int BPR_W  = AMP_W + TEN_W;
    localparam int NPR_W  = AMP_W + LEN_W;
    localparam int SPR_W  = MOD_W + LEN_W;
    localparam logic [PB-1:0] BLINK_TH = PB'(((64'd1 << PB) * 64'd2) / 64'd5);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;

    logic                       trig_reg;
    logic [EFFECT_W-1:0]        eff_reg;
    logic                       drop_reg;
    logic [EFFECT_W-1:0]        cur_eff_reg;
    logic                       playing_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [PB-1:0]              main_phase_reg;
    logic [PB-1:0]              second_phase_reg;
    logic [NOISE_W-1:0]         noise_reg;
    logic [ENV_W-1:0]           env_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       nz_neg_reg;
    logic [MOD_W-1:0]           nz_mag_reg;
    logic                       active_reg;
    logic                       last_reg;

    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic                       m_active_reg;
    logic                       m_last_reg;
    logic                       m_drop_reg;

    // ------------------------------------------------------------------
    // Queue and shared divider
    // ------------------------------------------------------------------
    logic                q_push, q_pop, q_full, q_empty;
    logic [EFFECT_W-1:0] q_data;
    div_req_t            div_req;
    logic [LW-1:0]       div_lo;
    logic                div_done;
    logic [LW-1:0]       div_quo;
    logic [DEN_W-1:0]    div_rem;

    sfx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (eff_reg),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    sfx_div #(
        .LW (LW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .req_lo  (div_lo),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // ------------------------------------------------------------------
    // Per-sample arithmetic feeding the divider and the waveform select
    // ------------------------------------------------------------------
    fx_desc_t                   fx;
    logic                       trig_ok;
    logic [LEN_W-1:0]           rem_len;
    logic signed [DFI_W-1:0]    dfi;
    logic signed [NUM_W-1:0]    num_full;
    logic [DEN_W-1:0]           num_clamp;
    logic [TEN_W-1:0]           ten_n;
    logic [TEN_W-1:0]           seven_i;
    logic [BPR_W-1:0]           blink_prod;
    logic [NPR_W-1:0]           norm_prod;
    logic [DIV_BITS-1:0]        env_div;
    logic [SPR_W-1:0]           slide_div;
    logic [NOISE_W-1:0]         lfsr_next;
    logic signed [MOD_W:0]      nz;
    logic [MOD_W-1:0]           nz_abs;
    logic [ENV_W-1:0]           env_now;
    logic signed [SAMPLE_W-1:0] env_s;
    logic signed [SAMPLE_W-1:0] wave_s;
    logic                       sq_a, sq_b;
    logic [PB:0]                twice, full_scale, saw_dist;
    logic [PB+ENV_W:0]          saw_prod;
    logic signed [SAMPLE_W-1:0] saw_mag;
    logic signed [SAMPLE_W-1:0] slide_mag;
    logic                       last_now;

    assign fx      = fx_lookup(cur_eff_reg);
    assign trig_ok = trig_reg && (eff_reg < EFFECT_W'(NUM_EFFECTS));
    assign rem_len = fx.len - LEN_W'(idx_reg);

    // start frequency plus sweep, scaled by len; clamp below zero
    assign dfi       = fx.df * $signed({1'b0, idx_reg});
    assign num_full  = $signed({3'b000, fx.f0n}) + NUM_W'(dfi);
    assign num_clamp = num_full[NUM_W-1] ? '0 : DEN_W'(num_full[NUM_W-2:0]);

    // envelope dividends: blink decays to three tenths, the rest to zero
    assign ten_n      = TEN_W'(fx.len) * 4'd10;
    assign seven_i    = TEN_W'(idx_reg) * 3'd7;
    assign blink_prod = fx.amp * (ten_n - seven_i);
    assign norm_prod  = fx.amp * rem_len;
    assign env_div    = (fx.kind == KIND_BLINK) ? blink_prod[DIV_BITS-1:0]
                                                : DIV_BITS'(norm_prod);
    assign slide_div  = nz_mag_reg * rem_len;

    // Galois LFSR, right shift
    assign lfsr_next = (noise_reg >> 1) ^ (noise_reg[0] ? LFSR_TAPS : '0);

    // centered noise value from the divider remainder
    assign nz     = $signed({1'b0, div_rem[MOD_W-1:0]}) - $signed({2'b00, fx.noise[MOD_W-1:1]});
    assign nz_abs = nz[MOD_W] ? MOD_W'(-nz) : nz[MOD_W-1:0];

    // square and two-tone waves from the updated phases
    assign env_now = div_quo[ENV_W-1:0];
    assign env_s   = $signed({2'b00, env_now});
    assign sq_a    = !main_phase_reg[PB-1];
    assign sq_b    = !second_phase_reg[PB-1];

    always_comb begin
        case (fx.kind)
            KIND_BLINK: wave_s = (main_phase_reg < BLINK_TH) ? env_s : -env_s;
            KIND_GEM:   wave_s = (sq_a == sq_b) ? (sq_a ? env_s : -env_s) : '0;
            default:    wave_s = sq_a ? env_s : -env_s;
        endcase
    end

    // sawtooth: distance of twice the phase from full scale, times the envelope
    assign twice      = {main_phase_reg, 1'b0};
    assign full_scale = (PB+1)'(1) << PB;
    assign saw_dist   = sq_a ? full_scale - twice : twice - full_scale;
    assign saw_prod   = saw_dist * env_reg;
    assign saw_mag    = $signed({2'b00, saw_prod[PB+ENV_W-1:PB]});
    assign slide_mag  = $signed({2'b00, div_quo[MOD_W-1:0]});

    assign last_now = (idx_reg == IDX_W'(fx.len - 1'b1));

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_PUSH;
            ST_PUSH:    state_next = ST_CHECK;
            ST_CHECK: begin
                if (playing_reg) begin
                    state_next = ST_INC;
                end else if (!q_empty) begin
                    state_next = ST_POP;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_POP:     state_next = ST_INC;
            ST_INC:     state_next = (fx.kind == KIND_NOISE) ? ST_NOISE : ST_INC_W;
            ST_INC_W:   if (div_done) state_next = (fx.kind == KIND_GEM) ? ST_INC2 : ST_ENV;
            ST_INC2:    state_next = ST_INC2_W;
            ST_INC2_W:  if (div_done) state_next = ST_ENV;
            ST_ENV:     state_next = ST_ENV_W;
            ST_ENV_W: begin
                if (div_done) begin
                    if (fx.kind == KIND_SAW) begin
                        state_next = ST_SAW;
                    end else if (fx.kind == KIND_SQ && fx.noise != '0) begin
                        state_next = ST_NOISE;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_NOISE:   state_next = ST_NOISE_W;
            ST_NOISE_W: if (div_done) state_next = (fx.kind == KIND_NOISE) ? ST_SLIDE : ST_FIN;
            ST_SLIDE:   state_next = ST_SLIDE_W;
            ST_SLIDE_W: if (div_done) state_next = ST_FIN;
            ST_SAW:     state_next = ST_FIN;
            ST_FIN:     state_next = ST_OUT;
            ST_OUT:     if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs and divider requests
    // ------------------------------------------------------------------
    logic out_load;

    always_comb begin
        s_tready = 1'b0;
        q_push   = 1'b0;
        q_pop    = 1'b0;
        out_load = 1'b0;
        div_req  = '0;
        div_lo   = '0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_PUSH:  q_push = trig_ok && !q_full;
            ST_CHECK: q_pop = !playing_reg && !q_empty;
            ST_INC: begin
                // phase increment = num * 2^PB / (rate * len)
                if (fx.kind != KIND_NOISE) begin
                    div_req.start = 1'b1;
                    div_req.hi    = num_clamp;
                    div_req.den   = fx.den;
                    div_req.steps = STEP_W'(PB);
                end
            end
            ST_INC2: begin
                div_req.start = 1'b1;
                div_req.hi    = DEN_W'(fx.f2n);
                div_req.den   = fx.den;
                div_req.steps = STEP_W'(PB);
            end
            ST_ENV: begin
                div_req.start = 1'b1;
                div_req.den   = (fx.kind == KIND_BLINK) ? DEN_W'(ten_n) : DEN_W'(fx.len);
                div_req.steps = STEP_W'(DIV_BITS);
                div_lo        = LW'(env_div) << (LW - DIV_BITS);
            end
            ST_NOISE: begin
                // remainder of the stepped LFSR value by the noise modulus
                div_req.start = 1'b1;
                div_req.den   = DEN_W'(fx.noise);
                div_req.steps = STEP_W'(NOISE_W);
                div_lo        = LW'(lfsr_next) << (LW - NOISE_W);
            end
            ST_SLIDE: begin
                div_req.start = 1'b1;
                div_req.den   = DEN_W'(fx.len);
                div_req.steps = STEP_W'(DIV_BITS);
                div_lo        = LW'(slide_div) << (LW - DIV_BITS);
            end
            ST_OUT:   out_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cur_eff_reg      <= '0;
            playing_reg      <= 1'b0;
            idx_reg          <= '0;
            main_phase_reg   <= '0;
            second_phase_reg <= '0;
            noise_reg        <= SEED_MIN;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            // start the oldest queued effect with both phases at zero
            if (state_reg == ST_POP) begin
                cur_eff_reg      <= q_data;
                playing_reg      <= 1'b1;
                idx_reg          <= '0;
                main_phase_reg   <= '0;
                second_phase_reg <= '0;
            end
            if (state_reg == ST_INC_W && div_done) begin
                main_phase_reg <= main_phase_reg + div_quo[PB-1:0];
            end
            if (state_reg == ST_INC2_W && div_done) begin
                second_phase_reg <= second_phase_reg + div_quo[PB-1:0];
            end
            // a seed write reloads the LFSR at once; zero would stall it
            if (cfg_valid) begin
                noise_reg <= (cfg_data == '0) ? SEED_MIN : cfg_data;
            end else if (state_reg == ST_NOISE) begin
                noise_reg <= lfsr_next;
            end
            // advance the sample index, stop after the final sample
            if (state_reg == ST_FIN) begin
                if (last_now) begin
                    playing_reg <= 1'b0;
                    idx_reg     <= '0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                trig_reg <= s_tuser;
                eff_reg  <= s_tdata[EFFECT_W-1:0];
            end
            ST_PUSH: begin
                drop_reg   <= trig_ok && q_full;
                sample_reg <= '0;
                active_reg <= 1'b0;
                last_reg   <= 1'b0;
            end
            ST_ENV_W: begin
                if (div_done) begin
                    env_reg    <= env_now;
                    sample_reg <= wave_s;
                end
            end
            ST_NOISE_W: begin
                if (div_done) begin
                    nz_neg_reg <= nz[MOD_W];
                    nz_mag_reg <= nz_abs;
                    sample_reg <= sample_reg + SAMPLE_W'(nz);
                end
            end
            ST_SLIDE_W: begin
                if (div_done) begin
                    sample_reg <= nz_neg_reg ? -slide_mag : slide_mag;
                end
            end
            ST_SAW:  sample_reg <= sq_a ? -saw_mag : saw_mag;
            ST_FIN: begin
                active_reg <= 1'b1;
                last_reg   <= last_now;
            end
            default: ;
        endcase

        // hold the result until the downstream side takes it
        if (out_load) begin
            m_sample_reg <= sample_reg;
            m_active_reg <= active_reg;
            m_last_reg   <= last_reg;
            m_drop_reg   <= drop_reg;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, m_sample_reg};
    assign m_tlast   = m_last_reg;
    assign m_tuser   = {m_drop_reg, m_active_reg};
    assign cfg_ready = 1'b1;

endmodule

FILE: design/sfx_checker.sv
// Port-level checker for the sound effect synth, bound to the top level.
// Depends on sound_effect_synth_assert.svh for the assertion macros.
`include "sound_effect_synth_assert.svh"

module sfx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    `SFX_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // the final sample always belongs to a playing effect
    `SFX_ASSERT_NOW(a_last_active, m_tvalid && m_tlast, m_tuser[0], "last set on an idle tick")

    // idle ticks carry silence
    `SFX_ASSERT_NOW(a_idle_zero, m_tvalid && !m_tuser[0], m_tdata == 16'd0, "idle tick with nonzero sample")

    // one tick at a time: busy right after an accepted transaction
    `SFX_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")

endmodule

bind sound_effect_synth sfx_checker u_sfx_checker (.*);
